// ===== rtl/core/tree_lowest_common_ancestor_assert.svh =====
// assertion macros for the tree lowest common ancestor block
// used by the top level only
`ifndef TREE_LOWEST_COMMON_ANCESTOR_ASSERT_SVH
`define TREE_LOWEST_COMMON_ANCESTOR_ASSERT_SVH
// a condition implies something at the next edge
`define TLCA_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("tlca check failed");
// a condition implies something at the same edge
`define TLCA_ASSERT_NOW(lbl, clk, rst_n, cond, now) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (now)) \
        else $error("tlca check failed");
`endif

// ===== rtl/core/tlca_pkg.sv =====
// shared types and codes for the tree lowest common ancestor block
// no dependencies
`timescale 1ns / 1ps
package tlca_pkg;
    localparam int MAX_NODES   = 1024;
    localparam int LIFT_LEVELS = 11;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD0, ST_ADD1,
        ST_CLR, ST_ROOT,
        ST_POP, ST_POPW, ST_HEAD, ST_EDGE, ST_EDGEW, ST_CHILD, ST_CHILDW,
        ST_LIFT, ST_LIFTW, ST_LIFTD,
        ST_QD, ST_QDW, ST_QSWAP,
        ST_QU, ST_QUW, ST_QUD, ST_QUDW,
        ST_QB, ST_QBW, ST_QFIN, ST_QFINW,
        ST_OUT
    } t_state;
endpackage

// ===== rtl/core/tree_lowest_common_ancestor.sv =====
// tree lowest common ancestor by binary lifting, top level
// depends on tlca_pkg and tree_lowest_common_ancestor_assert.svh
`timescale 1ns / 1ps
// one item at a time under a small sequencer around single-port memories
// with registered reads (heads, edges, depths, ancestor table, walk queue).
// after reset a clearing pass empties the heads and marks every depth
// unvisited; ready stays low until it ends. build clears the depths,
// zeroes the sentinel and root rows, then walks the tree: it pops each
// node, reads its edge entries, and fills the ancestor row of each new
// child. a query raises its result sooner when one node turns out to
// sit above the other. ready is high only when idle and no result waits.
// node ids at or above MAX_NODES follow the same rules: ignored, answer
// 0, or an empty walk.
`include "tree_lowest_common_ancestor_assert.svh"
module tree_lowest_common_ancestor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [9:0] i_node_a,
    input  logic [9:0] i_node_b,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [9:0] o_ancestor
);
    import tlca_pkg::*;

    localparam int NW = $clog2(MAX_NODES);           // node index width
    localparam int EW = NW + 1;                      // edge index / depth width
    localparam int KW = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int AW = $clog2(MAX_NODES * LIFT_LEVELS);
    localparam logic [EW:0]   SLOTS = (EW+1)'(2 * MAX_NODES);
    localparam logic [EW-1:0] DNONE = EW'(2 * MAX_NODES - 1);
    localparam logic [KW-1:0] KTOP  = KW'(LIFT_LEVELS - 1);

    // memories
    logic [EW-1:0] m_head  [MAX_NODES];
    logic [9:0]    m_tgt   [2*MAX_NODES];
    logic [EW-1:0] m_next  [2*MAX_NODES];
    logic [EW-1:0] m_depth [MAX_NODES];
    logic [9:0]    m_anc   [MAX_NODES*LIFT_LEVELS];
    logic [NW-1:0] m_queue [MAX_NODES];
    // heads and depths are cleared by a pass after reset
    logic [EW-1:0] r_head_q, r_next_q, r_depth_q;
    logic [9:0]    r_tgt_d, r_anc_q;
    logic [NW-1:0] r_queue_q;

    t_state r_state, n_state;
    logic [9:0]    r_root;
    logic [EW-1:0] r_ecnt;
    logic [9:0]    r_a, r_b, r_t, r_j, r_up;
    logic [EW-1:0] r_e, r_da, r_db, r_dt;
    logic [NW:0]   r_qh, r_qt, r_cnt;
    logic [KW-1:0] r_k;
    logic          r_ovalid, r_init;
    logic [9:0]    r_res;

    // memory ports, driven by the sequencer
    logic          hd_we, tg_we, dp_we, an_we, qu_we;
    logic [NW-1:0] hd_addr, dp_addr, qu_addr;
    logic [EW-1:0] hd_wd, ed_addr, dp_wd;
    logic [9:0]    tg_wd, an_wd;
    logic [EW-1:0] nx_wd;
    logic [AW-1:0] an_addr;
    logic [NW-1:0] qu_wd;

    always_ff @(posedge i_clk) begin
        if (hd_we) m_head[hd_addr] <= hd_wd;
        r_head_q <= m_head[hd_addr];
        if (tg_we) begin
            m_tgt[ed_addr[NW:0]]  <= tg_wd;
            m_next[ed_addr[NW:0]] <= nx_wd;
        end
        r_tgt_d  <= m_tgt[ed_addr[NW:0]];
        r_next_q <= m_next[ed_addr[NW:0]];
        if (dp_we) m_depth[dp_addr] <= dp_wd;
        r_depth_q <= m_depth[dp_addr];
        if (an_we) m_anc[an_addr] <= an_wd;
        r_anc_q <= m_anc[an_addr];
        if (qu_we) m_queue[qu_addr] <= qu_wd;
        r_queue_q <= m_queue[qu_addr];
    end

    function automatic logic [AW-1:0] aidx(input logic [9:0] v, input logic [KW-1:0] k);
        logic [AW+10:0] p;
        p = (AW+11)'(v) * (AW+11)'(LIFT_LEVELS) + (AW+11)'(k);
        return p[AW-1:0];
    endfunction

    function automatic logic inr(input logic [9:0] v);
        return (11'(v) < 11'(MAX_NODES));
    endfunction

    logic n_ovalid;
    logic [9:0] n_res, n_a, n_b, n_t, n_j, n_up;
    logic [EW-1:0] n_ecnt, n_e, n_da, n_db, n_dt;
    logic [NW:0] n_qh, n_qt, n_cnt;
    logic [KW-1:0] n_k;
    logic n_init;

    assign o_ready    = (r_state == ST_IDLE) && !r_ovalid && r_init;
    assign o_valid    = r_ovalid;
    assign o_ancestor = r_res;

    always_comb begin
        n_state = r_state; n_ovalid = r_ovalid; n_res = r_res;
        n_a = r_a; n_b = r_b; n_t = r_t; n_j = r_j; n_up = r_up;
        n_ecnt = r_ecnt; n_e = r_e; n_da = r_da; n_db = r_db; n_dt = r_dt;
        n_qh = r_qh; n_qt = r_qt; n_cnt = r_cnt; n_k = r_k; n_init = r_init;
        hd_we = 1'b0; tg_we = 1'b0; dp_we = 1'b0; an_we = 1'b0; qu_we = 1'b0;
        hd_addr = r_a[NW-1:0]; hd_wd = '0; ed_addr = r_e; tg_wd = r_b; nx_wd = '0;
        dp_addr = r_a[NW-1:0]; dp_wd = DNONE; an_addr = aidx(r_a, r_k); an_wd = '0;
        qu_addr = r_qh[NW-1:0]; qu_wd = r_j[NW-1:0];
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // reset pass clears heads and depths
                if (!r_init) begin
                    hd_we = 1'b1; hd_addr = r_cnt[NW-1:0]; hd_wd = '0;
                    dp_we = 1'b1; dp_addr = r_cnt[NW-1:0]; dp_wd = DNONE;
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == (NW+1)'(MAX_NODES - 1)) n_init = 1'b1;
                end else if (i_valid && o_ready) begin
                    n_a = i_node_a; n_b = i_node_b;
                    case (i_command)
                        CMD_ADD: begin
                            hd_addr = i_node_a[NW-1:0];
                            if (inr(i_node_a) && inr(i_node_b)
                                && ({1'b0, r_ecnt} + (EW+1)'(2) < SLOTS))
                                n_state = ST_ADD0;
                        end
                        CMD_BUILD: begin n_cnt = '0; n_state = ST_CLR; end
                        CMD_QUERY: begin
                            if (inr(i_node_a) && inr(i_node_b)) begin
                                dp_addr = i_node_a[NW-1:0]; n_state = ST_QD;
                            end else begin
                                n_res = '0; n_state = ST_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD0: begin
                // r_head_q holds head[a]
                ed_addr = r_ecnt + 1'b1; tg_we = 1'b1; tg_wd = r_b; nx_wd = r_head_q;
                hd_we = 1'b1; hd_addr = r_a[NW-1:0]; hd_wd = r_ecnt + 1'b1;
                n_ecnt = r_ecnt + 1'b1; n_state = ST_ADD1;
                hd_addr = r_a[NW-1:0];
            end
            ST_ADD1: begin
                hd_addr = r_b[NW-1:0];  // read head[b]
                n_state = ST_HEAD;       // reuse a wait: handled below
                n_cnt = '1;
            end
            ST_CLR: begin
                dp_we = 1'b1; dp_addr = r_cnt[NW-1:0];
                dp_wd = (r_cnt == '0) ? '0 : DNONE;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (NW+1)'(MAX_NODES - 1)) begin
                    n_k = '0; n_state = inr(r_root) ? ST_ROOT : ST_IDLE;
                end
            end
            ST_ROOT: begin
                // zero rows of sentinel and root, one entry a cycle
                an_we = 1'b1; an_wd = '0;
                an_addr = r_cnt[0] ? aidx(r_root, r_k) : aidx(10'd0, r_k);
                n_cnt[0] = ~r_cnt[0];
                if (r_cnt[0]) begin
                    if (r_k == KTOP) begin
                        dp_we = 1'b1; dp_addr = r_root[NW-1:0]; dp_wd = EW'(1);
                        qu_we = 1'b1; qu_addr = '0; qu_wd = r_root[NW-1:0];
                        n_qh = '0; n_qt = (NW+1)'(1); n_state = ST_POP;
                    end else n_k = r_k + 1'b1;
                end
            end
            ST_POP: begin
                if (r_qh < r_qt) begin qu_addr = r_qh[NW-1:0]; n_state = ST_POPW; end
                else n_state = ST_IDLE;
            end
            ST_POPW: begin
                n_t = 10'(r_queue_q); n_qh = r_qh + 1'b1;
                hd_addr = r_queue_q; dp_addr = r_queue_q; n_cnt = '0;
                n_state = ST_HEAD;
            end
            ST_HEAD: begin
                if (r_cnt == '1) begin
                    // second half of add edge: head[b] now readable
                    ed_addr = r_ecnt + 1'b1; tg_we = 1'b1; tg_wd = r_a; nx_wd = r_head_q;
                    hd_we = 1'b1; hd_addr = r_b[NW-1:0]; hd_wd = r_ecnt + 1'b1;
                    n_ecnt = r_ecnt + 1'b1; n_cnt = '0; n_state = ST_IDLE;
                end else begin
                    n_e = r_head_q; n_dt = r_depth_q; n_state = ST_EDGE;
                end
            end
            ST_EDGE: begin
                if (r_e != '0 && {1'b0, r_e} < SLOTS) begin
                    ed_addr = r_e; n_state = ST_EDGEW;
                end else n_state = ST_POP;
            end
            ST_EDGEW: begin
                n_j = r_tgt_d; n_e = r_next_q; dp_addr = r_tgt_d[NW-1:0];
                n_state = inr(r_tgt_d) ? ST_CHILD : ST_EDGE;
            end
            ST_CHILD: begin
                if (r_depth_q > r_dt + 1'b1) begin
                    dp_we = 1'b1; dp_addr = r_j[NW-1:0]; dp_wd = r_dt + 1'b1;
                    if (r_qt < (NW+1)'(MAX_NODES)) begin
                        qu_we = 1'b1; qu_addr = r_qt[NW-1:0]; qu_wd = r_j[NW-1:0];
                        n_qt = r_qt + 1'b1;
                    end
                    an_we = 1'b1; an_addr = aidx(r_j, '0); an_wd = r_t;
                    n_up = r_t; n_k = KW'(1);
                    n_state = (LIFT_LEVELS > 1) ? ST_LIFT : ST_EDGE;
                end else n_state = ST_EDGE;
            end
            ST_LIFT: begin
                // read entry (mid, k-1)
                an_addr = aidx(r_up, r_k - 1'b1); n_state = ST_LIFTW;
            end
            ST_LIFTW: begin
                // hold the address so the read data stays put
                an_addr = aidx(r_up, r_k - 1'b1); n_state = ST_LIFTD;
            end
            ST_LIFTD: begin
                an_we = 1'b1; an_addr = aidx(r_j, r_k);
                an_wd = inr(r_up) ? r_anc_q : '0;
                n_up = an_wd;
                if (r_k == KTOP) n_state = ST_EDGE;
                else begin n_k = r_k + 1'b1; n_state = ST_LIFT; end
            end
            ST_QD: begin n_da = r_depth_q; dp_addr = r_b[NW-1:0]; n_state = ST_QDW; end
            ST_QDW: begin n_db = r_depth_q; n_state = ST_QSWAP; end
            ST_QSWAP: begin
                if (r_da < r_db) begin
                    n_a = r_b; n_b = r_a; n_da = r_db; n_db = r_da;
                end
                n_k = KTOP; n_state = ST_QU;
            end
            ST_QU: begin an_addr = aidx(r_a, r_k); n_state = ST_QUW; end
            ST_QUW: begin dp_addr = r_anc_q[NW-1:0]; n_up = r_anc_q; n_state = ST_QUD; end
            ST_QUD: begin dp_addr = r_up[NW-1:0]; n_state = ST_QUDW; end
            ST_QUDW: begin
                if (r_depth_q >= r_db) n_a = r_up;
                if (r_k == '0) begin
                    if (n_a == r_b) begin n_res = n_a; n_state = ST_OUT; end
                    else begin n_k = KTOP; n_state = ST_QB; end
                end else begin n_k = r_k - 1'b1; n_state = ST_QU; end
            end
            ST_QB: begin an_addr = aidx(r_a, r_k); n_cnt = '0; n_state = ST_QBW; end
            ST_QBW: begin
                if (r_cnt == '0) begin
                    n_up = r_anc_q; an_addr = aidx(r_b, r_k); n_cnt = (NW+1)'(1);
                end else if (r_cnt == (NW+1)'(1)) begin
                    an_addr = aidx(r_b, r_k); n_cnt = (NW+1)'(2);
                end else begin
                    if (r_up != r_anc_q) begin n_a = r_up; n_b = r_anc_q; end
                    if (r_k == '0) n_state = ST_QFIN;
                    else begin n_k = r_k - 1'b1; n_state = ST_QB; end
                end
            end
            ST_QFIN: begin an_addr = aidx(r_a, '0); n_state = ST_QFINW; end
            ST_QFINW: begin n_res = r_anc_q; n_state = ST_OUT; end
            ST_OUT: begin
                if (!r_ovalid) begin n_ovalid = 1'b1; n_state = ST_IDLE; end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ovalid <= 1'b0; r_root <= 10'd1;
            r_ecnt <= '0; r_cnt <= '0; r_init <= 1'b0;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid; r_ecnt <= n_ecnt;
            r_cnt <= n_cnt; r_init <= n_init;
            if (i_cfg_we) r_root <= i_cfg_data;
        end
        r_res <= n_res; r_a <= n_a; r_b <= n_b; r_t <= n_t; r_j <= n_j;
        r_up <= n_up; r_e <= n_e; r_da <= n_da; r_db <= n_db; r_dt <= n_dt;
        r_qh <= n_qh; r_qt <= n_qt; r_k <= n_k;
    end

    // checks
    `TLCA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_ancestor))
    `TLCA_ASSERT_NOW(a_busy, i_clk, i_rst_n, r_state != ST_IDLE, !o_ready)
    `TLCA_ASSERT_NOW(a_ecnt, i_clk, i_rst_n, 1'b1, {1'b0, r_ecnt} < SLOTS)
endmodule

// ===== test/tree_lca_checker.sv =====
// watches both channels of tree_lowest_common_ancestor, predicts each ancestor and compares
// depends on tlca_pkg for the command codes
`timescale 1ns / 1ps
module tree_lca_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [9:0]        i_cfg_data,
    input  logic              i_valid,
    input  logic              i_ready,
    input  logic [1:0]        i_command,
    input  logic [9:0]        i_node_a,
    input  logic [9:0]        i_node_b,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [9:0]        i_ancestor,
    output int                o_fail,
    output int                o_pending,
    output bit  [1023:0]      o_rows
);
    import tlca_pkg::*;

    localparam int NODES  = 1024;
    localparam int LEVELS = 11;
    localparam int SLOTS  = 2048;
    localparam logic [10:0] UNSEEN = 11'h7ff;

    logic [10:0] adj_head [NODES];
    logic [9:0]  edge_to [SLOTS];
    logic [10:0] edge_link [SLOTS];
    int          used_slots;
    logic [10:0] level [NODES];
    logic [9:0]  jump [NODES][LEVELS];
    logic [9:0]  root_sel;
    logic [9:0]  lca_due [$];
    bit          written [NODES];
    int          fails;

    assign o_fail    = fails;
    assign o_pending = lca_due.size();
    always_comb begin
        for (int v = 0; v < NODES; v++) o_rows[v] = written[v];
    end

    function automatic void link_edge(input logic [9:0] from, input logic [9:0] to);
        used_slots++;
        edge_to[used_slots]   = to;
        edge_link[used_slots] = adj_head[from];
        adj_head[from]        = used_slots[10:0];
    endfunction

    // breadth-first walk from the root, one ancestor row per newly reached node
    function automatic void rebuild_tree();
        logic [9:0]  fifo [NODES];
        int          rd;
        int          wr;
        logic [9:0]  t;
        logic [9:0]  j;
        logic [10:0] e;
        for (int v = 0; v < NODES; v++) level[v] = UNSEEN;
        level[0]        = '0;
        level[root_sel] = 11'd1;
        for (int k = 0; k < LEVELS; k++) begin
            jump[0][k]        = '0;
            jump[root_sel][k] = '0;
        end
        written[0]        = 1;
        written[root_sel] = 1;
        fifo[0] = root_sel;
        rd = 0;
        wr = 1;
        while (rd < wr) begin
            t = fifo[rd];
            rd++;
            e = adj_head[t];
            while (e != 0) begin
                j = edge_to[e];
                if (int'(level[j]) > int'(level[t]) + 1) begin
                    level[j] = level[t] + 11'd1;
                    if (wr < NODES) begin
                        fifo[wr] = j;
                        wr++;
                    end
                    jump[j][0] = t;
                    for (int k = 1; k < LEVELS; k++) jump[j][k] = jump[jump[j][k-1]][k-1];
                    written[j] = 1;
                end
                e = edge_link[e];
            end
        end
    endfunction

    function automatic logic [9:0] common_ancestor(input logic [9:0] a, input logic [9:0] b);
        logic [9:0] t;
        if (level[a] < level[b]) begin
            t = a;
            a = b;
            b = t;
        end
        for (int k = LEVELS - 1; k >= 0; k--) begin
            if (level[jump[a][k]] >= level[b]) a = jump[a][k];
        end
        if (a == b) return a;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            if (jump[a][k] != jump[b][k]) begin
                a = jump[a][k];
                b = jump[b][k];
            end
        end
        return jump[a][0];
    endfunction

    always @(posedge i_clk) begin
        logic [9:0] want;
        if (!i_rst_n) begin
            for (int v = 0; v < NODES; v++) begin
                adj_head[v] = '0;
                level[v]    = UNSEEN;
                written[v]  = 0;
            end
            used_slots = 0;
            root_sel   = 10'd1;
            lca_due.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) root_sel = i_cfg_data;
            if (i_res_valid && i_res_ready) begin
                if (lca_due.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected ancestor beat %0d", i_ancestor);
                end else begin
                    want = lca_due.pop_front();
                    if (want !== i_ancestor) begin
                        fails++;
                        if (fails <= 10)
                            $display("ancestor expected %0d actual %0d", want, i_ancestor);
                    end
                end
            end
            if (i_valid && i_ready) begin
                case (i_command)
                    CMD_ADD: begin
                        if (used_slots + 2 < SLOTS) begin
                            link_edge(i_node_a, i_node_b);
                            link_edge(i_node_b, i_node_a);
                        end
                    end
                    CMD_BUILD: rebuild_tree();
                    CMD_QUERY: lca_due.push_back(common_ancestor(i_node_a, i_node_b));
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== test/tb.sv =====
// stimulus and verdict for tree_lowest_common_ancestor
// depends on tlca_pkg, the block and tree_lca_checker
`timescale 1ns / 1ps
module tb;
    import tlca_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;   // unused code, block ignores it
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 6000000;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_cfg_we = 0;
    logic [9:0] i_cfg_data = '0;
    logic       i_valid = 0;
    logic       o_ready;
    logic [1:0] i_command = '0;
    logic [9:0] i_node_a = '0;
    logic [9:0] i_node_b = '0;
    logic       o_valid;
    logic       i_ready = 0;
    logic [9:0] o_ancestor;

    int          fail_count;
    int          pending;
    bit [1023:0] rows;

    // idling knobs, changed per phase
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;

    // nodes joined to the growing tree
    bit member [1024];
    int member_list [$];

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    tree_lowest_common_ancestor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_node_a   (i_node_a),
        .i_node_b   (i_node_b),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_ancestor (o_ancestor)
    );

    tree_lca_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_ready     (o_ready),
        .i_command   (i_command),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .i_res_valid (o_valid),
        .i_res_ready (i_ready),
        .i_ancestor  (o_ancestor),
        .o_fail      (fail_count),
        .o_pending   (pending),
        .o_rows      (rows)
    );

    // result side: random stalls, plus a long hold-off whenever a new token shows up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tree_lowest_common_ancestor: mismatch");
            $finish;
        end
    end

    // offer one beat; valid stays up into the next beat unless a gap is drawn
    task automatic send(input logic [1:0] cmd, input logic [9:0] a, input logic [9:0] b);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_node_a  <= a;
        i_node_b  <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // stop offering and wait until every ancestor is back and the block sits idle
    task automatic drain();
        i_valid <= 1'b0;
        repeat (3) @(posedge i_clk);
        while (pending != 0 || !o_ready) @(posedge i_clk);
    endtask

    task automatic set_root(input logic [9:0] r);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= r;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mode(input int m);
        case (m)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 79; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 79; end
            default: begin idle_pct = 29; stall_pct = 29; end
        endcase
    endtask

    task automatic join_node(input logic [9:0] n);
        if (!member[n]) begin
            member[n] = 1;
            member_list.push_back(int'(n));
        end
    endtask

    // well-formed growth: hang a fresh node under a random tree node, or add a random edge if none is found
    task automatic grow_edge();
        int p;
        int n;
        int tries;
        p = member_list[$urandom_range(0, member_list.size() - 1)];
        n = 0;
        for (tries = 0; tries < 20 && n == 0; tries++) begin
            n = $urandom_range(1, 1023);
            if (member[n]) n = 0;
        end
        if (n == 0) begin
            send(CMD_ADD, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        end else begin
            join_node(10'(n));
            if ($urandom_range(0, 1)) send(CMD_ADD, 10'(p), 10'(n));
            else send(CMD_ADD, 10'(n), 10'(p));
        end
    endtask

    // only nodes whose ancestor row some build has written
    function automatic logic [9:0] pick_node();
        int n;
        if ($urandom_range(0, 3) != 0) begin
            for (int t = 0; t < 10; t++) begin
                n = member_list[$urandom_range(0, member_list.size() - 1)];
                if (rows[n]) return 10'(n);
            end
        end
        do n = $urandom_range(0, 1023); while (!rows[n]);
        return 10'(n);
    endfunction

    task automatic noise_item();
        logic [1:0] c;
        c = ($urandom_range(0, 9) == 0) ? CMD_SPARE : CMD_ADD;
        send(c, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    endtask

    initial begin
        logic [9:0] r;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: small tree with a leaf at the top id, an edge to the sentinel,
        // a spare command, then queries across branches and on a single node
        join_node(1);
        set_root(10'd1);
        send(CMD_ADD, 10'd1, 10'd2);
        send(CMD_ADD, 10'd2, 10'd3);
        send(CMD_ADD, 10'd1, 10'd4);
        send(CMD_ADD, 10'd4, 10'd1023);
        send(CMD_ADD, 10'd5, 10'd0);
        send(CMD_ADD, 10'd3, 10'd5);
        send(CMD_ADD, 10'd6, 10'd7);
        send(CMD_SPARE, 10'h3ff, 10'h3ff);
        foreach (member[i]) if (i >= 2 && i <= 5) join_node(10'(i));
        join_node(1023);
        send(CMD_BUILD, 10'd0, 10'd0);
        send(CMD_QUERY, 10'd3, 10'd4);
        send(CMD_QUERY, 10'd2, 10'd3);
        send(CMD_QUERY, 10'd1, 10'd1);
        send(CMD_QUERY, 10'd1023, 10'd5);
        send(CMD_QUERY, 10'd0, 10'd3);
        send(CMD_QUERY, 10'd1, 10'd1023);
        // root in a separate component: the old tree goes unvisited
        set_root(10'd6);
        send(CMD_BUILD, 10'd0, 10'd0);
        send(CMD_QUERY, 10'd3, 10'd4);
        send(CMD_QUERY, 10'd6, 10'd7);
        send(CMD_QUERY, 10'd5, 10'd6);
        send(CMD_QUERY, 10'd1023, 10'd1023);

        // random phases: grow the tree, rebuild from a fresh root, then query hard
        for (int ph = 0; ph < 14; ph++) begin
            set_mode(ph % 4);
            if (ph == 3) r = 10'd1023;
            else if (ph == 5) r = 10'd1;
            else r = 10'(member_list[$urandom_range(0, member_list.size() - 1)]);
            set_root(r);
            for (int i = 0; i < 35; i++) begin
                if ($urandom_range(0, 99) < 85) grow_edge();
                else noise_item();
            end
            send(CMD_BUILD, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
            for (int i = 0; i < 50; i++) begin
                // long hold-off on the result side so the input backs up
                if (ph == 2 && i == 20) hold_token++;
                send(CMD_QUERY, pick_node(), pick_node());
            end
        end

        // fill the edge store until adds are dropped, then a last build
        set_mode(3);
        set_root(10'(member_list[$urandom_range(0, member_list.size() - 1)]));
        for (int i = 0; i < 700; i++) noise_item();
        send(CMD_BUILD, 10'd0, 10'd0);
        for (int i = 0; i < 20; i++) send(CMD_QUERY, pick_node(), pick_node());

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tree_lowest_common_ancestor: match");
        end else begin
            $display("tree_lowest_common_ancestor: mismatch");
        end
        $finish;
    end
endmodule
